// ----- rtl/cpbd_pkg.sv -----
// Shared types and constants for the cassette pulse byte decoder.
// Used by cpbd_core and cassette_pulse_byte_decoder; no dependencies.
`timescale 1ns / 1ps

package cpbd_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);

  localparam int SAMPLE_W = 8;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int INDEX_W  = 8;
  localparam int CFG_W    = 16;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 8'd170;
  localparam logic [7:0]          CLOCK_GAP_RST  = 8'd10;
  localparam logic [7:0]          BURN_RST       = 8'd5;
  localparam logic [COUNT_W-1:0]  LIMIT_RST      = 16'd500;
  localparam logic [7:0]          INIT_SKIP_RST  = 8'd0;
  localparam logic [COUNT_W-1:0]  COUNT_MAX      = '1;

  typedef enum logic [INDEX_W-1:0] {
    REG_THRESHOLD  = 8'd0,
    REG_CLOCK_GAP  = 8'd1,
    REG_BURN       = 8'd2,
    REG_LIMIT      = 8'd3,
    REG_INIT_SKIP  = 8'd4
  } cpbd_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pulse_threshold;
    logic [7:0]          clock_gap;
    logic [7:0]          burn_count;
    logic [COUNT_W-1:0]  byte_limit;
    logic [7:0]          start_skip;
  } cpbd_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              timed_out;
  } cpbd_res_t;

endpackage

// ----- rtl/cpbd_core.sv -----
// Per-sample decode state and its update, applied on each step.
// Depends on cpbd_pkg.
`timescale 1ns / 1ps

module cpbd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [cpbd_pkg::SAMPLE_W-1:0] sample,
  input  cpbd_pkg::cpbd_cfg_t           cfg,
  output cpbd_pkg::cpbd_res_t           res
);

  logic [7:0]                       skip_left, skip_left_next;
  logic                             bit_pending, bit_pending_next;
  logic [cpbd_pkg::BYTE_W-1:0]      shift_value, shift_value_next;
  logic [cpbd_pkg::BIT_CNT_W-1:0]   bit_count, bit_count_next;
  logic [cpbd_pkg::COUNT_W-1:0]     sample_count, sample_count_next;
  logic                             lookahead_due, lookahead_due_next;
  logic [7:0]                       burn_left, burn_left_next;
  logic                             timeout_armed, timeout_armed_next;

  logic                             level;
  logic [7:0]                       ahead_less_one;
  logic [cpbd_pkg::COUNT_W-1:0]     count_inc;
  logic [cpbd_pkg::BYTE_W-1:0]      shifted;
  logic [cpbd_pkg::BIT_CNT_W-1:0]   bits_inc;

  assign level          = sample >= cfg.pulse_threshold;
  assign ahead_less_one = (cfg.clock_gap == 8'd0) ? 8'd0 : cfg.clock_gap - 8'd1;
  assign count_inc      = (sample_count == cpbd_pkg::COUNT_MAX) ? sample_count
                                                                 : sample_count + 1'b1;
  assign shifted        = {shift_value[cpbd_pkg::BYTE_W-2:0], level};
  assign bits_inc       = bit_count + 1'b1;

  // res is the result this sample would give; state moves only on step
  always_comb begin
    skip_left_next     = skip_left;
    bit_pending_next   = bit_pending;
    shift_value_next   = shift_value;
    bit_count_next     = bit_count;
    sample_count_next  = sample_count;
    lookahead_due_next = lookahead_due;
    burn_left_next     = burn_left;
    timeout_armed_next = timeout_armed;
    res                = '0;

    if (burn_left != 8'd0) begin
      burn_left_next = burn_left - 8'd1;
    end else if (lookahead_due) begin
      lookahead_due_next = 1'b0;
      skip_left_next     = level ? cfg.clock_gap : ahead_less_one;
    end else begin
      sample_count_next = count_inc;
      if (timeout_armed && (count_inc > cfg.byte_limit)) begin
        timeout_armed_next = 1'b0;
        skip_left_next     = cfg.start_skip;
        bit_pending_next   = 1'b0;
        shift_value_next   = '0;
        bit_count_next     = '0;
        sample_count_next  = '0;
        res.valid          = 1'b1;
        res.timed_out      = 1'b1;
      end else if (skip_left != 8'd0) begin
        skip_left_next = skip_left - 8'd1;
      end else if (bit_pending) begin
        bit_pending_next = 1'b0;
        if (bits_inc >= cpbd_pkg::BIT_CNT_W'(cpbd_pkg::BITS_PER_BYTE)) begin
          res.valid          = 1'b1;
          res.data_byte      = shifted;
          timeout_armed_next = 1'b1;
          burn_left_next     = cfg.burn_count;
          skip_left_next     = cfg.start_skip;
          shift_value_next   = '0;
          bit_count_next     = '0;
          sample_count_next  = '0;
        end else begin
          shift_value_next = shifted;
          bit_count_next   = bits_inc;
          skip_left_next   = ahead_less_one;
        end
      end else if (level) begin
        bit_pending_next   = 1'b1;
        lookahead_due_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left     <= cpbd_pkg::INIT_SKIP_RST;
      bit_pending   <= 1'b0;
      shift_value   <= '0;
      bit_count     <= '0;
      sample_count  <= '0;
      lookahead_due <= 1'b0;
      burn_left     <= 8'd0;
      timeout_armed <= 1'b0;
    end else if (step) begin
      skip_left     <= skip_left_next;
      bit_pending   <= bit_pending_next;
      shift_value   <= shift_value_next;
      bit_count     <= bit_count_next;
      sample_count  <= sample_count_next;
      lookahead_due <= lookahead_due_next;
      burn_left     <= burn_left_next;
      timeout_armed <= timeout_armed_next;
    end
  end

  a_burn_silent: assert property (@(posedge clk) disable iff (rst)
    (burn_left != 8'd0) |-> !res.valid)
    else $error("result during burn-off");

  a_timeout_armed: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.timed_out) |=> !timeout_armed)
    else $error("timeout left armed");

  a_byte_arms: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && !res.timed_out) |=> timeout_armed
      && (burn_left == $past(cfg.burn_count)))
    else $error("byte did not arm timeout or load burn-off");

endmodule

// ----- rtl/cassette_pulse_byte_decoder.sv -----
// Top level: configuration registers, input register, decode core, output register.
// Depends on cpbd_pkg and cpbd_core.
// A sample's result, if any, is registered in the output register when it advances.
// Throughput: one sample per cycle; the input register holds only while the output
// register is full and stalled and the held sample would produce a result.
// Reset: synchronous; registers return to their defaults, decode state clears.
`timescale 1ns / 1ps

module cassette_pulse_byte_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,    // [7:0] sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,    // [7:0] data_byte
  output logic                          m_tuser,    // [0] timed_out
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpbd_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [cpbd_pkg::CFG_W-1:0]    cfg_data
);

  cpbd_pkg::cpbd_cfg_t          cfg;
  cpbd_pkg::cpbd_res_t          res;
  logic                         in_valid;
  logic [cpbd_pkg::SAMPLE_W-1:0] in_sample;
  logic                         advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_threshold <= cpbd_pkg::THRESHOLD_RST;
      cfg.clock_gap       <= cpbd_pkg::CLOCK_GAP_RST;
      cfg.burn_count      <= cpbd_pkg::BURN_RST;
      cfg.byte_limit      <= cpbd_pkg::LIMIT_RST;
      cfg.start_skip      <= cpbd_pkg::INIT_SKIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpbd_pkg::REG_THRESHOLD:  cfg.pulse_threshold <= cfg_data[7:0];
        cpbd_pkg::REG_CLOCK_GAP:  cfg.clock_gap       <= cfg_data[7:0];
        cpbd_pkg::REG_BURN:       cfg.burn_count      <= cfg_data[7:0];
        cpbd_pkg::REG_LIMIT:      cfg.byte_limit      <= cfg_data;
        cpbd_pkg::REG_INIT_SKIP:  cfg.start_skip      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // advance the held sample unless its result has nowhere to go
  assign advance  = in_valid && (!m_tvalid || m_tready || !res.valid);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata;
    end
  end

  cpbd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (in_sample),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= res.data_byte;
      m_tuser <= res.timed_out;
    end
  end

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
    else $error("timeout transaction carries data");

  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_sample)))
    else $error("held sample lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(advance && res.valid))
    else $error("pending result overwritten");

endmodule
